/* rtl/dcrms_pkg.sv */
// Package for the DC-corrected RMS block: shared constants, control and status
// structs, and the stride helper functions. Depends on nothing else.
package dcrms_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int STRIDE_W   = 4;
   localparam int PHASE_W    = 3;
   localparam int RMS_W      = 16;
   localparam int WORK_W     = 64;
   localparam int ROOT_W     = 32;
   localparam int ITER_W     = 7;
   localparam int K_W        = 6;

   localparam logic [STRIDE_W-1:0] STRIDE_PLAIN = 4'd1;
   localparam logic [STRIDE_W-1:0] STRIDE_IQ    = 4'd2;
   localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 4'd8;

   typedef struct packed {
      logic                start;
      logic                ack;
      logic [STRIDE_W-1:0] stride;
   } dcrms_ctl_type;

   typedef struct packed {
      logic             done;
      logic [RMS_W-1:0] rms;
   } dcrms_status_type;

   // Zero behaves as one, and anything above eight is held at eight.
   function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] raw);
      logic [STRIDE_W-1:0] st;
      st = raw;
      if (raw == '0) begin
         st = STRIDE_PLAIN;
      end else if (raw > STRIDE_MAX) begin
         st = STRIDE_MAX;
      end
      return st;
   endfunction

   // Weight st*(st-2) applied to t*t for strides of three and up.
   function automatic logic [K_W-1:0] stride_gain(input logic [STRIDE_W-1:0] st);
      logic [K_W-1:0] k;
      case (st)
         4'd3:    k = 6'd3;
         4'd4:    k = 6'd8;
         4'd5:    k = 6'd15;
         4'd6:    k = 6'd24;
         4'd7:    k = 6'd35;
         4'd8:    k = 6'd48;
         default: k = 6'd0;
      endcase
      return k;
   endfunction

endpackage

/* rtl/dcrms_finish.sv */
// End-of-block arithmetic: multiplies, the divide by L*L and the integer square
// root, all stepped through one shared 64-bit add/subtract unit. Uses dcrms_pkg.
module dcrms_finish
   import dcrms_pkg::*;
#(
   parameter int SUM_W = 28,
   parameter int SQS_W = 43,
   parameter int CNT_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  dcrms_ctl_type    ctl,
   input  logic [SUM_W-1:0] mag,
   input  logic [SQS_W-1:0] sqs,
   input  logic [CNT_W-1:0] len,
   output dcrms_status_type status
);

   localparam logic [3:0] F_IDLE = 4'd0;
   localparam logic [3:0] F_TT   = 4'd1;
   localparam logic [3:0] F_PL   = 4'd2;
   localparam logic [3:0] F_K    = 4'd3;
   localparam logic [3:0] F_SUB  = 4'd4;
   localparam logic [3:0] F_LL   = 4'd5;
   localparam logic [3:0] F_DIV  = 4'd6;
   localparam logic [3:0] F_SQRT = 4'd7;
   localparam logic [3:0] F_DONE = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic [WORK_W-1:0]   acc_ff, acc_in;
   logic [WORK_W-1:0]   mcand_ff, mcand_in;
   logic [SUM_W-1:0]    mult_ff, mult_in;
   logic [WORK_W-1:0]   tt_ff, tt_in;
   logic [WORK_W-1:0]   n_ff, n_in;
   logic [WORK_W-1:0]   dvs_ff, dvs_in;
   logic [WORK_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SQS_W-1:0]    sqs_ff, sqs_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [STRIDE_W-1:0] st_ff, st_in;

   logic [WORK_W-1:0]   alu_a, alu_b, alu_sum;
   logic                alu_sub, borrow;
   logic [WORK_W:0]     alu_full;
   logic [WORK_W-1:0]   mul_acc, div_shift, sqrt_shift, sqrt_trial;
   logic                last_iter;

   assign div_shift  = {rem_ff[WORK_W-2:0], n_ff[WORK_W-1]};
   assign sqrt_shift = {rem_ff[WORK_W-3:0], n_ff[WORK_W-1:WORK_W-2]};
   assign sqrt_trial = {{(WORK_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign last_iter  = (cnt_ff == ITER_W'(1));

   // The one adder/subtractor; every arithmetic phase borrows it.
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = mcand_ff;
      alu_sub = 1'b0;
      case (state_ff)
         F_SUB: begin
            alu_b   = tt_ff;
            alu_sub = 1'b1;
         end
         F_DIV: begin
            alu_a   = div_shift;
            alu_b   = dvs_ff;
            alu_sub = 1'b1;
         end
         F_SQRT: begin
            alu_a   = sqrt_shift;
            alu_b   = sqrt_trial;
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign alu_full = {1'b0, alu_a} + {1'b0, alu_b ^ {WORK_W{alu_sub}}} + (WORK_W+1)'(alu_sub);
   assign alu_sum  = alu_full[WORK_W-1:0];
   assign borrow   = alu_sub & ~alu_full[WORK_W];
   assign mul_acc  = mult_ff[0] ? alu_sum : acc_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mult_in  = mult_ff;
      tt_in    = tt_ff;
      n_in     = n_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      sqs_in   = sqs_ff;
      len_in   = len_ff;
      st_in    = st_ff;
      case (state_ff)
         F_IDLE: begin
            if (ctl.start) begin
               sqs_in   = sqs;
               len_in   = len;
               st_in    = ctl.stride;
               acc_in   = '0;
               mcand_in = WORK_W'(mag);
               mult_in  = mag;
               cnt_in   = ITER_W'(SUM_W);
               state_in = F_TT;
            end
         end
         F_TT, F_PL, F_K, F_LL: begin
            // Shift-and-add multiply, one multiplier bit per cycle.
            acc_in   = mul_acc;
            mcand_in = {mcand_ff[WORK_W-2:0], 1'b0};
            mult_in  = mult_ff >> 1;
            cnt_in   = cnt_ff - ITER_W'(1);
            if (last_iter) begin
               case (state_ff)
                  F_TT: begin
                     tt_in    = mul_acc;
                     acc_in   = '0;
                     mcand_in = WORK_W'(sqs_ff);
                     mult_in  = SUM_W'(len_ff);
                     cnt_in   = ITER_W'(CNT_W);
                     state_in = F_PL;
                  end
                  F_PL: begin
                     if (st_ff > STRIDE_IQ) begin
                        mcand_in = tt_ff;
                        mult_in  = SUM_W'(stride_gain(st_ff));
                        cnt_in   = ITER_W'(K_W);
                        state_in = F_K;
                     end else if (st_ff == STRIDE_PLAIN) begin
                        state_in = F_SUB;
                     end else begin
                        n_in     = mul_acc;
                        acc_in   = '0;
                        mcand_in = WORK_W'(len_ff);
                        mult_in  = SUM_W'(len_ff);
                        cnt_in   = ITER_W'(CNT_W);
                        state_in = F_LL;
                     end
                  end
                  F_K: begin
                     n_in     = mul_acc;
                     acc_in   = '0;
                     mcand_in = WORK_W'(len_ff);
                     mult_in  = SUM_W'(len_ff);
                     cnt_in   = ITER_W'(CNT_W);
                     state_in = F_LL;
                  end
                  default: begin
                     dvs_in  = mul_acc;
                     rem_in  = '0;
                     root_in = '0;
                     if (mul_acc == '0) begin
                        n_in     = '0;
                        cnt_in   = ITER_W'(ROOT_W);
                        state_in = F_SQRT;
                     end else begin
                        cnt_in   = ITER_W'(WORK_W);
                        state_in = F_DIV;
                     end
                  end
               endcase
            end
         end
         F_SUB: begin
            // Plain stride subtracts t*t and clamps at zero.
            n_in     = borrow ? '0 : alu_sum;
            acc_in   = '0;
            mcand_in = WORK_W'(len_ff);
            mult_in  = SUM_W'(len_ff);
            cnt_in   = ITER_W'(CNT_W);
            state_in = F_LL;
         end
         F_DIV: begin
            // Restoring division; quotient bits shift into the dividend register.
            n_in   = {n_ff[WORK_W-2:0], ~borrow};
            rem_in = borrow ? div_shift : alu_sum;
            cnt_in = cnt_ff - ITER_W'(1);
            if (last_iter) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = ITER_W'(ROOT_W);
               state_in = F_SQRT;
            end
         end
         F_SQRT: begin
            // Two radicand bits per step, trial subtract of 4*root+1.
            rem_in  = borrow ? sqrt_shift : alu_sum;
            root_in = {root_ff[ROOT_W-2:0], ~borrow};
            n_in    = {n_ff[WORK_W-3:0], 2'b00};
            cnt_in  = cnt_ff - ITER_W'(1);
            if (last_iter) begin
               state_in = F_DONE;
            end
         end
         F_DONE: begin
            if (ctl.ack) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
      tt_ff    <= tt_in;
      n_ff     <= n_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      sqs_ff   <= sqs_in;
      len_ff   <= len_in;
      st_ff    <= st_in;
   end

   assign status.done = (state_ff == F_DONE);
   assign status.rms  = (|root_ff[ROOT_W-1:RMS_W]) ? '1 : root_ff[RMS_W-1:0];

endmodule

/* rtl/dc_corrected_rms_top.sv */
// A non-last request is absorbed in its accept cycle; after a last request the result
// is formed by the bit-serial multiplies, divide and root on one adder and then moves
// to the output register. Throughput: one request per cycle within a block; req_ready
// is low while a block is being finished. Reset (synchronous, active high) clears the
// sums, the stride phase, the overflow flag and the handshakes, and sets stride to one.
module dc_corrected_rms_top
   import dcrms_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [RMS_W-1:0]           rsp_rms_value,
   output logic                       rsp_overflowed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [STRIDE_W-1:0]        csr_stride
);

   // Accumulator widths follow from the longest block that is counted.
   localparam int SUM_W = $clog2(MAX_LEN) + SAMPLE_W;
   localparam int SQS_W = $clog2(MAX_LEN) + 2*SAMPLE_W - 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [STRIDE_W-1:0]     stride_ff, stride_in;
   logic signed [SUM_W-1:0] sample_sum_ff, sample_sum_in;
   logic [SQS_W-1:0]        square_sum_ff, square_sum_in;
   logic [CNT_W-1:0]        item_count_ff, item_count_in;
   logic [PHASE_W-1:0]      stride_phase_ff, stride_phase_in;
   logic                    overflow_flag_ff, overflow_flag_in;
   logic                    busy_ff, busy_in;
   logic                    ovf_hold_ff, ovf_hold_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]        rsp_rms_value_ff, rsp_rms_value_in;
   logic                    rsp_overflowed_ff, rsp_overflowed_in;

   logic                    req_fire, out_load;
   logic [STRIDE_W-1:0]     st;
   logic                    ovf_now, take;
   logic [PHASE_W-1:0]      phase_cur, phase_next;
   logic [STRIDE_W-1:0]     phase_inc;
   logic [SAMPLE_W-1:0]     smag;
   logic [2*SAMPLE_W-1:0]   ssq;
   logic signed [SUM_W-1:0] sum_upd;
   logic [SQS_W-1:0]        sqs_upd;
   logic [CNT_W-1:0]        cnt_upd;
   logic [PHASE_W-1:0]      phase_upd;
   logic                    ovf_upd;
   logic [SUM_W-1:0]        sum_mag;

   dcrms_ctl_type           fin_ctl;
   dcrms_status_type        fin_status;

   // The block takes requests whenever no block is being finished, even while an
   // earlier result still sits in the output register.
   assign req_ready = ~busy_ff;
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // Decimation: the phase wraps to zero when it has reached the current stride,
   // so a stride change in the middle of a block takes effect at once.
   assign st         = eff_stride(stride_ff);
   assign ovf_now    = (item_count_ff >= CNT_W'(MAX_LEN));
   assign phase_cur  = ({1'b0, stride_phase_ff} >= st) ? '0 : stride_phase_ff;
   assign take       = (phase_cur == '0);
   assign phase_inc  = {1'b0, phase_cur} + STRIDE_W'(1);
   assign phase_next = (phase_inc >= st) ? '0 : phase_inc[PHASE_W-1:0];

   // Sample magnitude and its square; the most negative sample maps to 2^15.
   assign smag = req_sample[SAMPLE_W-1] ? SAMPLE_W'(-req_sample) : SAMPLE_W'(req_sample);
   assign ssq  = (2*SAMPLE_W)'(smag) * (2*SAMPLE_W)'(smag);

   // Sums as they stand once the current request has been counted. A request
   // beyond MAX_LEN only raises the overflow flag.
   always_comb begin
      sum_upd   = sample_sum_ff;
      sqs_upd   = square_sum_ff;
      cnt_upd   = item_count_ff;
      phase_upd = stride_phase_ff;
      ovf_upd   = overflow_flag_ff | ovf_now;
      if (!ovf_now) begin
         if (take) begin
            sum_upd = sample_sum_ff + SUM_W'(req_sample);
            sqs_upd = square_sum_ff + SQS_W'(ssq);
         end
         phase_upd = phase_next;
         cnt_upd   = item_count_ff + CNT_W'(1);
      end
   end

   assign sum_mag = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);

   // A finished result moves to the output register once that register is free
   // or is being emptied in the same cycle.
   assign out_load = fin_status.done & (~rsp_valid_ff | rsp_ready);

   assign fin_ctl.start  = req_fire & req_last;
   assign fin_ctl.ack    = out_load;
   assign fin_ctl.stride = st;

   dcrms_finish #(
      .SUM_W (SUM_W),
      .SQS_W (SQS_W),
      .CNT_W (CNT_W)
   ) u_finish (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fin_ctl),
      .mag    (sum_mag),
      .sqs    (sqs_upd),
      .len    (cnt_upd),
      .status (fin_status)
   );

   always_comb begin
      stride_in         = stride_ff;
      sample_sum_in     = sample_sum_ff;
      square_sum_in     = square_sum_ff;
      item_count_in     = item_count_ff;
      stride_phase_in   = stride_phase_ff;
      overflow_flag_in  = overflow_flag_ff;
      busy_in           = busy_ff;
      ovf_hold_in       = ovf_hold_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_rms_value_in  = rsp_rms_value_ff;
      rsp_overflowed_in = rsp_overflowed_ff;

      if (csr_valid && csr_ready) begin
         stride_in = csr_stride;
      end

      if (req_fire) begin
         if (req_last) begin
            // The finishing unit captures the final sums now; the block starts over.
            sample_sum_in    = '0;
            square_sum_in    = '0;
            item_count_in    = '0;
            stride_phase_in  = '0;
            overflow_flag_in = 1'b0;
            ovf_hold_in      = ovf_upd;
            busy_in          = 1'b1;
         end else begin
            sample_sum_in    = sum_upd;
            square_sum_in    = sqs_upd;
            item_count_in    = cnt_upd;
            stride_phase_in  = phase_upd;
            overflow_flag_in = ovf_upd;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in      = 1'b1;
         rsp_rms_value_in  = fin_status.rms;
         rsp_overflowed_in = ovf_hold_ff;
         busy_in           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff        <= STRIDE_PLAIN;
         sample_sum_ff    <= '0;
         square_sum_ff    <= '0;
         item_count_ff    <= '0;
         stride_phase_ff  <= '0;
         overflow_flag_ff <= 1'b0;
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         stride_ff        <= stride_in;
         sample_sum_ff    <= sample_sum_in;
         square_sum_ff    <= square_sum_in;
         item_count_ff    <= item_count_in;
         stride_phase_ff  <= stride_phase_in;
         overflow_flag_ff <= overflow_flag_in;
         busy_ff          <= busy_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_hold_ff       <= ovf_hold_in;
      rsp_rms_value_ff  <= rsp_rms_value_in;
      rsp_overflowed_ff <= rsp_overflowed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rms_value  = rsp_rms_value_ff;
   assign rsp_overflowed = rsp_overflowed_ff;

endmodule

/* rtl/dcrms_check.sv */
// Port-level checker for the DC-corrected RMS block, bound to its top level.
// Uses dcrms_pkg for field widths.
module dcrms_check
   import dcrms_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [RMS_W-1:0]   rsp_rms_value,
   input logic               rsp_overflowed
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_value)
                                  && $stable(rsp_overflowed))
      else $error("result changed while stalled");

   // Closing a block starts the finishing sequence, so no request is taken next.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken right after the last of a block");

   // Requests within a block never stall the input.
   a_mid_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> req_ready)
      else $error("input stalled in the middle of a block");

   // A new result appears only as a block finishes, which frees the input.
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && $past(!req_ready))
      else $error("result appeared without a finished block");

endmodule

bind dc_corrected_rms_top dcrms_check u_check (.*);

/* test/tb_dc_corrected_rms_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dc_corrected_rms_top: drives sample blocks and stride writes,
// predicts each block's DC-corrected RMS in a scoreboard class and checks every response.
// Depends on dcrms_pkg and the dc_corrected_rms_top RTL.
module tb_dc_corrected_rms_top;
   import dcrms_pkg::*;

   // The block length limit given to the DUT, and the predictor's copy of it.
   localparam int BLOCK_LIMIT    = 4096;
   // Idle pad long enough to cover a block's finishing pass, with margin.
   localparam int SETTLE_CYCLES  = 200;
   // Length of the one long receiver hold-off.
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_REQUESTS = 100;
   localparam int MAX_PRINTED    = 40;
   // Generous bound on the whole run, several times the slowest legal run.
   localparam longint LIMIT_NS   = 20_000_000;

   // One expected response: the RMS estimate and the overflow flag of a block.
   typedef struct {
      logic [RMS_W-1:0] rms;
      logic             overflowed;
   } rms_expect_type;

   // The scoreboard keeps its own copy of the stride register and the block accumulators.
   // Each accepted request under the limit is counted and, if the stride takes it, summed;
   // one flagged last produces one expected response, queued until the DUT returns it.
   class rms_scoreboard;
      logic [STRIDE_W-1:0] stride_reg;
      longint              run_sum;
      bit [63:0]           square_acc;
      int                  block_len;
      int                  phase;
      bit                  overflow_seen;
      rms_expect_type      rms_due[$];
      int                  errors;

      function new();
         stride_reg = STRIDE_PLAIN;
         errors = 0;
         clear_block();
      endfunction

      function void clear_block();
         run_sum = 0;
         square_acc = '0;
         block_len = 0;
         phase = 0;
         overflow_seen = 1'b0;
      endfunction

      task report_mismatch(input string what);
         if (errors < MAX_PRINTED) begin
            $display("%0t: mismatch: %s", $time, what);
         end
         errors++;
      endtask

      function void absorb_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
         bit [63:0]      st;
         bit [63:0]      len;
         bit [63:0]      t_mag;
         bit [63:0]      t_sq;
         bit [63:0]      num;
         bit [63:0]      quot;
         bit [63:0]      root;
         bit [63:0]      trial;
         rms_expect_type due;
         // A stride of zero acts as one; anything above the maximum is held there.
         if (stride_reg == '0) begin
            st = 64'd1;
         end else if (stride_reg > STRIDE_MAX) begin
            st = 64'(STRIDE_MAX);
         end else begin
            st = 64'(stride_reg);
         end
         if (block_len >= BLOCK_LIMIT) begin
            overflow_seen = 1'b1;
         end else begin
            if (phase >= st) phase = 0;
            if (phase == 0) begin
               run_sum += longint'(smp);
               square_acc += 64'(longint'(smp) * longint'(smp));
            end
            phase = (phase + 1 >= st) ? 0 : phase + 1;
            block_len++;
         end
         if (!lst) return;
         len = 64'(block_len);
         t_mag = (run_sum < 0) ? 64'(-run_sum) : 64'(run_sum);
         t_sq = t_mag * t_mag;
         num = square_acc * len;
         if (st == 64'd1) begin
            num = (t_sq > num) ? 64'd0 : num - t_sq;
         end else if (st >= 64'd3) begin
            num += t_sq * st * (st - 64'd2);
         end
         quot = (len != 0) ? num / (len * len) : 64'd0;
         // Integer square root, one result bit at a time from the top.
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= quot) root = trial;
         end
         due.rms = (root > 64'd65535) ? '1 : root[RMS_W-1:0];
         due.overflowed = overflow_seen;
         rms_due.push_back(due);
         clear_block();
      endfunction

      task check_result(input logic [RMS_W-1:0] rms, input logic ovf);
         rms_expect_type due;
         if (rms_due.size() == 0) begin
            report_mismatch($sformatf("response rms_value %0d with no block outstanding", rms));
            return;
         end
         due = rms_due.pop_front();
         if (rms !== due.rms) begin
            report_mismatch($sformatf("rms_value %0d, expected %0d", rms, due.rms));
         end
         if (ovf !== due.overflowed) begin
            report_mismatch($sformatf("overflowed %0b, expected %0b", ovf, due.overflowed));
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [RMS_W-1:0]           rsp_rms_value;
   logic                       rsp_overflowed;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [STRIDE_W-1:0]        csr_stride = STRIDE_PLAIN;

   rms_scoreboard board;

   // Idle rates in percent. The sender's rate is only read by the main process; the
   // receiver's rate is updated with nonblocking writes so the receiver sees it cleanly.
   int   tx_idle_pct = 20;
   int   rx_idle_pct = 20;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;

   dc_corrected_rms_top #(
      .MAX_LEN(BLOCK_LIMIT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rms_value  (rsp_rms_value),
      .rsp_overflowed (rsp_overflowed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_stride     (csr_stride)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one request, with random idle cycles in front of it, and waits for the edge
   // that accepts it. The task is entered and left in the time step of a rising edge, so
   // valid is either kept high for the next request or lowered by the caller, never both.
   task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_last <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.absorb_sample(smp, lst);
   endtask

   // Stops offering requests and waits until every expected response has come back,
   // then lets the block settle for the length of its finishing pass.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.rms_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The stride register is only written with the block idle.
   task automatic write_stride(input logic [STRIDE_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_stride <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.stride_reg = value;
   endtask

   // Sends one block of the given length with the last flag on its final request.
   // The content style is chosen per block: full-range noise, a DC offset with a little
   // noise on it, full-scale extremes only, or small values near zero.
   task automatic send_random_block(input int len);
      int style;
      int dc;
      int v;
      style = $urandom_range(3);
      dc = int'($urandom_range(65535)) - 32768;
      for (int i = 0; i < len; i++) begin
         case (style)
            0: v = int'($urandom_range(65535)) - 32768;
            1: begin
               v = dc + int'($urandom_range(256)) - 128;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
            end
            2: v = $urandom_range(1) ? 32767 : -32768;
            default: v = int'($urandom_range(64)) - 32;
         endcase
         send_item(SAMPLE_W'(v), i == len - 1);
      end
   endtask

   // The receiver checks each accepted response against the oldest expectation and then
   // picks its ready for the next cycle. A hold request from the main process starts one
   // long stretch with ready low, counted here so the sender keeps running meanwhile.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_rms_value, rsp_overflowed);
      end
      if (hold_request && !hold_taken) begin
         hold_left = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      int sent;
      int len;
      int roll;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A stride of zero must behave as one; the block covers both
      // full-scale extremes, zero and minus one.
      write_stride(4'd0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh0000, 1'b0);
      send_item(16'shFFFF, 1'b1);
      // A one-request block at stride one, where the DC term cancels the power exactly.
      send_item(16'sh8000, 1'b1);

      // At the largest stride a single full-scale request gives a root well above the
      // 16-bit range, so the response must saturate.
      write_stride(STRIDE_MAX);
      send_item(16'sh8000, 1'b1);
      send_item(16'sh7FFF, 1'b1);

      // A stride above the maximum is held at the maximum.
      write_stride(4'hF);
      send_item(16'sd100, 1'b0);
      send_item(-16'sd5, 1'b0);
      send_item(16'sd7, 1'b1);

      // Interleaved I/Q stride, where the DC correction term drops out.
      write_stride(STRIDE_IQ);
      send_item(16'sd1000, 1'b0);
      send_item(-16'sd1000, 1'b0);
      send_item(16'sd3000, 1'b0);
      send_item(-16'sd3000, 1'b0);
      send_item(16'sd500, 1'b1);

      // Stride changed in the middle of a block: five requests at stride eight leave the
      // phase at five, so the change to three must wrap the phase back to zero.
      write_stride(STRIDE_MAX);
      for (int i = 0; i < 5; i++) send_item(SAMPLE_W'($urandom_range(65535)), 1'b0);
      write_stride(4'd3);
      for (int i = 0; i < 4; i++) send_item(SAMPLE_W'($urandom_range(65535)), i == 3);

      // Random part in phases, each with its own stride. Phase two runs with no idling on
      // either side, and phase three starts with the long receiver hold-off so that the
      // block fills up and stalls its input while the sender keeps offering requests.
      // Every phase boundary also pauses the sender until all responses are back.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: write_stride(STRIDE_PLAIN);
            1: write_stride(STRIDE_MAX);
            2: write_stride(STRIDE_IQ);
            default: write_stride(STRIDE_W'($urandom_range(15)));
         endcase
         tx_idle_pct = (p == 2 || p == 3) ? 0 : 20;
         rx_idle_pct <= (p == 2) ? 0 : 20;
         if (p == 3) hold_request <= 1'b1;
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            // Mostly short blocks, some medium ones and now and then a long one.
            roll = $urandom_range(99);
            if (roll < 70) begin
               len = $urandom_range(12, 1);
            end else if (roll < 95) begin
               len = $urandom_range(64, 13);
            end else begin
               len = $urandom_range(300, 65);
            end
            send_random_block(len);
            sent += len;
         end
      end

      wait_drained();
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   initial begin
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
rtl/dcrms_pkg.sv
rtl/dcrms_finish.sv
rtl/dc_corrected_rms_top.sv
rtl/dcrms_check.sv
test/tb_dc_corrected_rms_top.sv
